@@ sv/rrcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrcp_pkg
// Types, stage map and helpers for the closest-points pipeline between two
// 3D lines in signed Q16.16.
// ----------------------------------------------------------------------------
package rrcp_pkg;

  typedef struct packed {
    logic signed [31:0] first_base_x;
    logic signed [31:0] first_base_y;
    logic signed [31:0] first_base_z;
    logic signed [31:0] first_dir_x;
    logic signed [31:0] first_dir_y;
    logic signed [31:0] first_dir_z;
    logic signed [31:0] second_base_x;
    logic signed [31:0] second_base_y;
    logic signed [31:0] second_base_z;
    logic signed [31:0] second_dir_x;
    logic signed [31:0] second_dir_y;
    logic signed [31:0] second_dir_z;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] first_param;
    logic signed [31:0] second_param;
    logic signed [31:0] first_point_x;
    logic signed [31:0] first_point_y;
    logic signed [31:0] first_point_z;
    logic signed [31:0] second_point_x;
    logic signed [31:0] second_point_y;
    logic signed [31:0] second_point_z;
  } rsp_t;

  // Everything an item carries down the pipe; unused fields get pruned.
  typedef struct packed {
    logic [2:0][31:0]  a0;     // first base
    logic [2:0][31:0]  a;      // first direction
    logic [2:0][31:0]  b0;     // second base
    logic [2:0][31:0]  b;      // second direction
    logic [20:0][47:0] term;   // floored dot product terms
    logic [6:0][31:0]  dot;
    logic [63:0]       pdd;
    logic [63:0]       pab;
    logic [31:0]       e;
    logic [31:0]       f;
    logic [63:0]       dv;
    logic [63:0]       ne;
    logic [63:0]       nf;
    logic [63:0]       num;
    logic              found;
    logic              neg;
    logic [63:0]       ud;
    logic [79:0]       rem;
    logic              ovf;
    logic [30:0]       q;
    logic [31:0]       w;
    logic [63:0]       wd;
    logic [2:0][63:0]  prod;
    logic [63:0]       tn;
    logic [63:0]       rem2;
    logic              tneg;
    logic              ovf2;
    logic [31:0]       q2;
    logic [31:0]       t;
    logic [2:0][31:0]  ptb;
    rsp_t              rsp;
  } ctx_t;

  // dot product slots
  localparam int DAB  = 0;
  localparam int DAB0 = 1;
  localparam int DAA0 = 2;
  localparam int DBB0 = 3;
  localparam int DBA0 = 4;
  localparam int DAA  = 5;
  localparam int DBB  = 6;

  // stage map
  localparam int S_DOT   = 1;
  localparam int S_DEN   = 2;
  localparam int S_DV    = 3;
  localparam int S_CHK   = 4;
  localparam int S_PREP  = 5;
  localparam int S_D1LO  = 6;
  localparam int S_D1HI  = 36;
  localparam int S_W     = 37;
  localparam int S_WMUL  = 38;
  localparam int S_TN    = 39;
  localparam int S_PREP2 = 40;
  localparam int S_D2LO  = 41;
  localparam int S_D2HI  = 72;
  localparam int S_T     = 73;
  localparam int S_TMUL  = 74;
  localparam int S_OUT   = 75;
  localparam int NST     = 76;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = SAT_MAX;
    else if (v < -66'sd2147483648) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] xx;
    logic signed [63:0] yy;
    xx = 64'(x);
    yy = 64'(y);
    return xx * yy;
  endfunction

  // floor16(base<<16 + p), saturated
  function automatic logic signed [31:0] point(input logic signed [31:0] base,
                                               input logic signed [63:0] p);
    logic signed [64:0] s;
    s = 65'($signed({base, 16'h0000})) + 65'(p);
    return sat32(66'($signed(s[64:16])));
  endfunction

endpackage

@@ sv/ray_ray_closest_points.sv @@
// ----------------------------------------------------------------------------
// ray_ray_closest_points
// Closest points between two 3D lines, signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless a stalled result holds the pipe; the two
//   31/32-stage restoring dividers and the multiplier stages are each one register step deep.
// The whole pipe advances unless the output holds a result under stall.
// Reset (rst, synchronous): pipe emptied, parallel_threshold = 1.
module ray_ray_closest_points (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrcp_pkg::req_t       in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrcp_pkg::rsp_t       out_data
);

  logic [30:0]       parallel_threshold;
  logic              adv;
  logic [rrcp_pkg::NST-1:0] vld;
  rrcp_pkg::ctx_t    st  [rrcp_pkg::NST];
  rrcp_pkg::ctx_t    nxt [rrcp_pkg::NST];

  assign adv       = !(vld[rrcp_pkg::NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[rrcp_pkg::NST-1];
  assign out_data  = st[rrcp_pkg::NST-1].rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_threshold <= 31'd1;
    end else if (cfg_we) begin
      parallel_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[rrcp_pkg::NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < rrcp_pkg::NST; s++) st[s] <= nxt[s];
    end
  end

  // stage 0: capture and the 21 products
  always_comb begin
    logic [3:0][2:0][31:0] v;
    logic signed [63:0] p;
    nxt[0] = '0;
    nxt[0].a0 = {in_data.first_base_z, in_data.first_base_y, in_data.first_base_x};
    nxt[0].a  = {in_data.first_dir_z, in_data.first_dir_y, in_data.first_dir_x};
    nxt[0].b0 = {in_data.second_base_z, in_data.second_base_y, in_data.second_base_x};
    nxt[0].b  = {in_data.second_dir_z, in_data.second_dir_y, in_data.second_dir_x};
    v = {nxt[0].b0, nxt[0].a0, nxt[0].b, nxt[0].a};   // 0 a, 1 b, 2 a0, 3 b0
    for (int i = 0; i < 3; i++) begin
      p = rrcp_pkg::mul32(v[0][i], v[1][i]);
      nxt[0].term[rrcp_pkg::DAB*3+i]  = p[63:16];
      p = rrcp_pkg::mul32(v[0][i], v[3][i]);
      nxt[0].term[rrcp_pkg::DAB0*3+i] = p[63:16];
      p = rrcp_pkg::mul32(v[0][i], v[2][i]);
      nxt[0].term[rrcp_pkg::DAA0*3+i] = p[63:16];
      p = rrcp_pkg::mul32(v[1][i], v[3][i]);
      nxt[0].term[rrcp_pkg::DBB0*3+i] = p[63:16];
      p = rrcp_pkg::mul32(v[1][i], v[2][i]);
      nxt[0].term[rrcp_pkg::DBA0*3+i] = p[63:16];
      p = rrcp_pkg::mul32(v[0][i], v[0][i]);
      nxt[0].term[rrcp_pkg::DAA*3+i]  = p[63:16];
      p = rrcp_pkg::mul32(v[1][i], v[1][i]);
      nxt[0].term[rrcp_pkg::DBB*3+i]  = p[63:16];
    end
  end

  for (genvar s = 1; s < rrcp_pkg::NST; s++) begin : g_stage
    if (s == rrcp_pkg::S_DOT) begin : g_dot
      always_comb begin
        logic signed [49:0] sm;
        nxt[s] = st[s-1];
        for (int j = 0; j < 7; j++) begin
          sm = 50'($signed(st[s-1].term[j*3])) + 50'($signed(st[s-1].term[j*3+1]))
             + 50'($signed(st[s-1].term[j*3+2]));
          nxt[s].dot[j] = rrcp_pkg::sat32(66'(sm));
        end
      end
    end else if (s == rrcp_pkg::S_DEN) begin : g_den
      always_comb begin
        logic signed [32:0] d;
        nxt[s] = st[s-1];
        nxt[s].pdd = rrcp_pkg::mul32(st[s-1].dot[rrcp_pkg::DAA], st[s-1].dot[rrcp_pkg::DBB]);
        nxt[s].pab = rrcp_pkg::mul32(st[s-1].dot[rrcp_pkg::DAB], st[s-1].dot[rrcp_pkg::DAB]);
        d = 33'($signed(st[s-1].dot[rrcp_pkg::DAB0])) - 33'($signed(st[s-1].dot[rrcp_pkg::DAA0]));
        nxt[s].e = rrcp_pkg::sat32(66'(d));
        d = 33'($signed(st[s-1].dot[rrcp_pkg::DBB0])) - 33'($signed(st[s-1].dot[rrcp_pkg::DBA0]));
        nxt[s].f = rrcp_pkg::sat32(66'(d));
      end
    end else if (s == rrcp_pkg::S_DV) begin : g_dv
      always_comb begin
        nxt[s] = st[s-1];
        nxt[s].dv = st[s-1].pdd - st[s-1].pab;
        nxt[s].ne = rrcp_pkg::mul32(st[s-1].dot[rrcp_pkg::DAB], st[s-1].e);
        nxt[s].nf = rrcp_pkg::mul32(st[s-1].dot[rrcp_pkg::DAA], st[s-1].f);
      end
    end else if (s == rrcp_pkg::S_CHK) begin : g_chk
      always_comb begin
        logic [63:0] ud;
        nxt[s] = st[s-1];
        ud = st[s-1].dv[63] ? (64'd0 - st[s-1].dv) : st[s-1].dv;
        nxt[s].ud  = ud;
        nxt[s].num = st[s-1].ne - st[s-1].nf;
        nxt[s].found = (st[s-1].dv != 64'd0) && (st[s-1].dot[rrcp_pkg::DAA] != 32'd0)
                    && (ud >= {17'd0, parallel_threshold, 16'h0000});
      end
    end else if (s == rrcp_pkg::S_PREP) begin : g_prep
      always_comb begin
        logic [63:0] un;
        nxt[s] = st[s-1];
        un = st[s-1].num[63] ? (64'd0 - st[s-1].num) : st[s-1].num;
        nxt[s].neg = st[s-1].num[63] ^ st[s-1].dv[63];
        nxt[s].ovf = {16'd0, un} >= ({16'd0, st[s-1].ud} << 15);
        nxt[s].rem = {un, 16'h0000};
        nxt[s].q   = '0;
      end
    end else if (s >= rrcp_pkg::S_D1LO && s <= rrcp_pkg::S_D1HI) begin : g_div1
      localparam int K = rrcp_pkg::S_D1HI - s;
      always_comb begin
        logic [94:0] dk;
        nxt[s] = st[s-1];
        // divisor shifted by up to 30 can exceed the 80-bit remainder
        dk = {31'd0, st[s-1].ud} << K;
        if ({15'd0, st[s-1].rem} >= dk) begin
          nxt[s].rem  = st[s-1].rem - dk[79:0];
          nxt[s].q[K] = 1'b1;
        end
      end
    end else if (s == rrcp_pkg::S_W) begin : g_w
      always_comb begin
        nxt[s] = st[s-1];
        if (st[s-1].ovf) nxt[s].w = st[s-1].neg ? rrcp_pkg::SAT_MIN : rrcp_pkg::SAT_MAX;
        else if (st[s-1].neg) nxt[s].w = 32'd0 - {1'b0, st[s-1].q};
        else nxt[s].w = {1'b0, st[s-1].q};
      end
    end else if (s == rrcp_pkg::S_WMUL) begin : g_wmul
      always_comb begin
        nxt[s] = st[s-1];
        nxt[s].wd = rrcp_pkg::mul32(st[s-1].w, st[s-1].dot[rrcp_pkg::DAB]);
        for (int i = 0; i < 3; i++) nxt[s].prod[i] = rrcp_pkg::mul32(st[s-1].w, st[s-1].b[i]);
      end
    end else if (s == rrcp_pkg::S_TN) begin : g_tn
      always_comb begin
        nxt[s] = st[s-1];
        nxt[s].tn = {{16{st[s-1].e[31]}}, st[s-1].e, 16'h0000} + st[s-1].wd;
        for (int i = 0; i < 3; i++)
          nxt[s].ptb[i] = rrcp_pkg::point(st[s-1].b0[i], st[s-1].prod[i]);
      end
    end else if (s == rrcp_pkg::S_PREP2) begin : g_prep2
      always_comb begin
        logic [63:0] ut;
        nxt[s] = st[s-1];
        ut = st[s-1].tn[63] ? (64'd0 - st[s-1].tn) : st[s-1].tn;
        nxt[s].tneg = st[s-1].tn[63];
        nxt[s].ovf2 = ut >= {st[s-1].dot[rrcp_pkg::DAA], 32'd0};
        nxt[s].rem2 = ut;
        nxt[s].q2   = '0;
      end
    end else if (s >= rrcp_pkg::S_D2LO && s <= rrcp_pkg::S_D2HI) begin : g_div2
      localparam int K = rrcp_pkg::S_D2HI - s;
      always_comb begin
        logic [63:0] dk;
        nxt[s] = st[s-1];
        dk = {32'd0, st[s-1].dot[rrcp_pkg::DAA]} << K;
        if (st[s-1].rem2 >= dk) begin
          nxt[s].rem2  = st[s-1].rem2 - dk;
          nxt[s].q2[K] = 1'b1;
        end
      end
    end else if (s == rrcp_pkg::S_T) begin : g_t
      always_comb begin
        nxt[s] = st[s-1];
        if (st[s-1].ovf2) nxt[s].t = st[s-1].tneg ? rrcp_pkg::SAT_MIN : rrcp_pkg::SAT_MAX;
        else if (!st[s-1].tneg) nxt[s].t = st[s-1].q2[31] ? rrcp_pkg::SAT_MAX : st[s-1].q2;
        else if (st[s-1].q2 > 32'h80000000) nxt[s].t = rrcp_pkg::SAT_MIN;
        else nxt[s].t = 32'd0 - st[s-1].q2;
      end
    end else if (s == rrcp_pkg::S_TMUL) begin : g_tmul
      always_comb begin
        nxt[s] = st[s-1];
        for (int i = 0; i < 3; i++) nxt[s].prod[i] = rrcp_pkg::mul32(st[s-1].t, st[s-1].a[i]);
      end
    end else begin : g_out
      always_comb begin
        nxt[s] = st[s-1];
        nxt[s].rsp = '0;
        if (st[s-1].found) begin
          nxt[s].rsp.found          = 1'b1;
          nxt[s].rsp.first_param    = st[s-1].t;
          nxt[s].rsp.second_param   = st[s-1].w;
          nxt[s].rsp.first_point_x  = rrcp_pkg::point(st[s-1].a0[0], st[s-1].prod[0]);
          nxt[s].rsp.first_point_y  = rrcp_pkg::point(st[s-1].a0[1], st[s-1].prod[1]);
          nxt[s].rsp.first_point_z  = rrcp_pkg::point(st[s-1].a0[2], st[s-1].prod[2]);
          nxt[s].rsp.second_point_x = st[s-1].ptb[0];
          nxt[s].rsp.second_point_y = st[s-1].ptb[1];
          nxt[s].rsp.second_point_z = st[s-1].ptb[2];
        end
      end
    end
  end

endmodule

@@ sv/rrcp_chk.sv @@
// ----------------------------------------------------------------------------
// rrcp_chk
// Port-level checks for ray_ray_closest_points.
// ----------------------------------------------------------------------------
module rrcp_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rrcp_pkg::rsp_t out_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // requests are only held off by a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // a not-found result carries zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.first_param == 0
      && out_data.second_param == 0 && out_data.first_point_x == 0
      && out_data.second_point_z == 0)
    else $error("not-found result has nonzero fields");

  // pipe is empty after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind ray_ray_closest_points rrcp_chk u_rrcp_chk (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks ray_ray_closest_points: directed line pairs (degenerate, parallel,
// skew, saturating) and random pairs under several thresholds, idle and stall mixes,
// each result compared field by field against an in-bench Q16.16 model.
// ----------------------------------------------------------------------------
module tb;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [30:0]    cfg_data = '0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  rrcp_pkg::req_t in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rrcp_pkg::rsp_t out_data;

  rrcp_pkg::rsp_t expected_points[$];
  logic [30:0]    threshold = 31'd1;
  int             in_idle_pct = 0;
  int             out_stall_pct = 0;
  logic           hold_off = 1'b0;
  int             mismatches = 0;

  ray_ray_closest_points u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint dot3(longint p[3], longint q[3]);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++) s += (p[i] * q[i]) >>> 16;
    return clamp32(s);
  endfunction

  function automatic rrcp_pkg::rsp_t closest_points(rrcp_pkg::req_t r, logic [30:0] thr);
    longint a0[3], a[3], b0[3], b[3];
    longint dab, dab0, daa0, dbb0, dba0, daa, dbb, dv, e, f, num, w, t, tn, mag;
    logic [127:0] un, ud;
    rrcp_pkg::rsp_t res;
    res = '0;
    a0 = '{r.first_base_x, r.first_base_y, r.first_base_z};
    a  = '{r.first_dir_x, r.first_dir_y, r.first_dir_z};
    b0 = '{r.second_base_x, r.second_base_y, r.second_base_z};
    b  = '{r.second_dir_x, r.second_dir_y, r.second_dir_z};
    dab = dot3(a, b);
    dab0 = dot3(a, b0);
    daa0 = dot3(a, a0);
    dbb0 = dot3(b, b0);
    dba0 = dot3(b, a0);
    daa = dot3(a, a);
    dbb = dot3(b, b);
    dv = daa * dbb - dab * dab;
    mag = dv < 0 ? -dv : dv;
    if (dv == 0 || daa == 0 || mag < (longint'(thr) <<< 16)) return res;
    e = clamp32(dab0 - daa0);
    f = clamp32(dbb0 - dba0);
    num = dab * e - daa * f;
    un = {64'd0, (num < 0 ? -num : num)};
    ud = {64'd0, mag};
    if (un / ud >= 128'd32768) w = ((num < 0) != (dv < 0)) ? -64'sd2147483648 : 64'sd2147483647;
    else begin
      w = longint'((un << 16) / ud);
      if ((num < 0) != (dv < 0)) w = -w;
    end
    tn = e * 65536 + w * dab;
    t = clamp32(tn / daa);  // daa > 0 here, so this truncates toward zero
    res.found = 1'b1;
    res.first_param = t[31:0];
    res.second_param = w[31:0];
    res.first_point_x = 32'(clamp32((a0[0] * 65536 + t * a[0]) >>> 16));
    res.first_point_y = 32'(clamp32((a0[1] * 65536 + t * a[1]) >>> 16));
    res.first_point_z = 32'(clamp32((a0[2] * 65536 + t * a[2]) >>> 16));
    res.second_point_x = 32'(clamp32((b0[0] * 65536 + w * b[0]) >>> 16));
    res.second_point_y = 32'(clamp32((b0[1] * 65536 + w * b[1]) >>> 16));
    res.second_point_z = 32'(clamp32((b0[2] * 65536 + w * b[2]) >>> 16));
    return res;
  endfunction

  // result side: check accepted results, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        rrcp_pkg::rsp_t exp;
        exp = expected_points.pop_front();
        if (out_data !== exp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch found exp %0b act %0b", exp.found, out_data.found);
            $display("  params exp %h %h act %h %h", exp.first_param, exp.second_param,
                     out_data.first_param, out_data.second_param);
            $display("  first pt exp %h %h %h act %h %h %h", exp.first_point_x,
                     exp.first_point_y, exp.first_point_z, out_data.first_point_x,
                     out_data.first_point_y, out_data.first_point_z);
            $display("  second pt exp %h %h %h act %h %h %h", exp.second_point_x,
                     exp.second_point_y, exp.second_point_z, out_data.second_point_x,
                     out_data.second_point_y, out_data.second_point_z);
          end
        end
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
  end

  task automatic send_lines(rrcp_pkg::req_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    expected_points.push_back(closest_points(r, threshold));
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_threshold(logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic rrcp_pkg::req_t mk_lines(int p[12]);
    rrcp_pkg::req_t r;
    r = {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]};
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9)) inside
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return '0;
      [3:4]: return $signed($urandom_range(32'h1ffff)) - 32'sh10000;     // within +-1.0
      default: return $signed($urandom_range(32'h3fffff)) - 32'sh200000; // within +-32
    endcase
  endfunction

  function automatic rrcp_pkg::req_t rand_lines();
    rrcp_pkg::req_t r;
    // mostly moderate geometry so that solutions are found and checked
    for (int i = 0; i < 12; i++) r[i*32 +: 32] = rand_coord();
    return r;
  endfunction

  task automatic test_directed();
    int one, mx, mn;
    one = 32'sh10000;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_lines(mk_lines('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));   // zero directions
    send_lines(mk_lines('{0, 0, 0, 0, 0, 0, 0, 0, one, one, 0, 0})); // first dir zero
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, one, 0, 2*one, 0, 0})); // parallel
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, 0, one, 0, one, 0}));   // skew, perpendicular
    send_lines(mk_lines('{one, 2*one, 3*one, one, one, 0, -one, 0, 5*one, 0, one, one}));
    send_lines(mk_lines('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx}));
    send_lines(mk_lines('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    send_lines(mk_lines('{mx, mn, mx, one, 0, 0, mn, mx, mn, 0, one, 0}));
    // near-parallel: tiny denominator, huge parameters saturate
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, mx, 0, one, 1, 0}));
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, mn, 0, one, 300, 0}));
    send_lines(mk_lines('{mx, 0, 0, 256, 256, 0, mn, 0, 0, 0, 256, 256}));
    send_lines(mk_lines('{-one, -one, -one, -one, one, -one, one, one, one, one, -one, -one}));
    drain();
  endtask

  task automatic test_thresholds();
    int one;
    one = 32'sh10000;
    set_threshold(31'd0);
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, one, 0, one, 0, 0}));  // exact zero div
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, 0, one, 1, 1, 0}));
    drain();
    set_threshold(31'h7fffffff);
    send_lines(mk_lines('{0, 0, 0, one, 0, 0, 0, 0, one, 0, one, 0}));
    send_lines(mk_lines('{0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 0}));
    drain();
    set_threshold(31'd16);
    for (int i = 0; i < 8; i++) send_lines(rand_lines());
    drain();
    set_threshold(31'd1);
  endtask

  task automatic test_random(int n, int in_pct, int out_pct);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    for (int i = 0; i < n; i++) send_lines(rand_lines());
    drain();
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 120; i++) send_lines(rand_lines());
    join
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_thresholds();
    test_random(130, 0, 0);
    test_random(100, 69, 0);
    test_random(100, 0, 69);
    test_random(100, 35, 35);
    set_threshold(31'($urandom_range(4096)));
    test_random(60, 35, 35);
    set_threshold(31'd1);
    test_backpressure();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
